/* rtl/itoa_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itoa_pkg
// Shared types, character codes and the digit encoder for the integer
// to ASCII formatter.
// ----------------------------------------------------------------------------
package itoa_pkg;

  localparam int unsigned MAX_DIGITS = 11;
  localparam int unsigned PAD_MAX    = 31;

  // 2^35 / 10 rounded up; (x * RECIP10) >> 35 == x / 10 for any 32-bit x
  localparam logic [31:0] RECIP10    = 32'hCCCC_CCCD;
  localparam int unsigned RECIP_SHFT = 35;

  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_SPACE = 8'h20;  // ' '
  localparam logic [7:0] CH_MINUS = 8'h2D;  // '-'
  localparam logic [7:0] CH_A     = 8'h41;  // 'A'

  typedef logic [3:0] digit_t;

  // quotient and digit from one division step
  typedef struct packed {
    logic [31:0] quot;
    digit_t      digit;
  } dig_res_t;

  function automatic logic [7:0] digit_char(input digit_t d);
    logic [7:0] c;
    if (d >= 4'd10) begin
      c = {4'b0, d} - 8'd10 + CH_A;
    end else begin
      c = {4'b0, d} + CH_ZERO;
    end
    return c;
  endfunction

endpackage

/* rtl/itoa_digit_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itoa_digit_unit
// Shared divide-by-base unit: one low digit and the quotient per use.
// Decimal goes through a registered reciprocal multiply, hex is a shift.
// ----------------------------------------------------------------------------
module itoa_digit_unit import itoa_pkg::*; (
  input  logic        clk,
  input  logic        load,
  input  logic        hex,
  input  logic [31:0] x,
  output dig_res_t    res
);

  logic [31:0] x_r, x_nxt;
  logic        hex_r, hex_nxt;
  logic [63:0] prod_r, prod_nxt;

  logic [31:0] q_dec;
  logic [31:0] q_times10;
  logic [31:0] rem_dec;

  always_comb begin
    x_nxt    = x_r;
    hex_nxt  = hex_r;
    prod_nxt = prod_r;
    if (load) begin
      x_nxt    = x;
      hex_nxt  = hex;
      prod_nxt = {32'b0, x} * {32'b0, RECIP10};
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    hex_r  <= hex_nxt;
    prod_r <= prod_nxt;
  end

  // remainder = x - 10*q, with 10*q as two shifted adds
  assign q_dec     = 32'(prod_r >> RECIP_SHFT);
  assign q_times10 = {q_dec[28:0], 3'b0} + {q_dec[30:0], 1'b0};
  assign rem_dec   = x_r - q_times10;

  always_comb begin
    if (hex_r) begin
      res.quot  = {4'b0, x_r[31:4]};
      res.digit = x_r[3:0];
    end else begin
      res.quot  = q_dec;
      res.digit = rem_dec[3:0];
    end
  end

endmodule

/* rtl/integer_to_ascii_formatter.sv */
`timescale 1ns / 1ps
// Each digit passes S_MUL (multiply), then S_DIG (digit write-back), up to 10
//   digits, then one character per cycle out unless out_stall holds it, up to 31 characters.
// A new number is taken only back in S_IDLE, after the last character; the
//   rate is set by the single shared divide-by-base unit and serial output.
// Reset: rst_n synchronous, active low; clears sequencer and output valid.
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter
// Formats a 32-bit value as decimal or upper-case hex ASCII, with optional
// sign and space or zero padding (padding ahead of the sign).
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter import itoa_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_value,
  input  logic        in_hex_base,
  input  logic        in_signed_mode,
  input  logic        in_zero_pad,
  input  logic [7:0]  in_pad_width,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_char_out,
  output logic        out_last
);

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;  // waiting for an input transfer
  localparam logic [1:0] S_MUL  = 2'd1;  // load divide unit
  localparam logic [1:0] S_DIG  = 2'd2;  // store digit, take quotient
  localparam logic [1:0] S_EMIT = 2'd3;  // stream characters out

  logic [1:0]  state_r, state_nxt;
  logic [31:0] mag_r, mag_nxt;
  logic        neg_r, neg_nxt;
  logic        hex_r, hex_nxt;
  logic        zp_r, zp_nxt;
  logic [4:0]  pad_r, pad_nxt;
  logic [3:0]  nd_r, nd_nxt;
  logic [4:0]  npad_r, npad_nxt;
  logic [4:0]  total_r, total_nxt;
  logic [4:0]  k_r, k_nxt;
  digit_t      digs_r [MAX_DIGITS];
  digit_t      digs_nxt [MAX_DIGITS];

  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_char_r, out_char_nxt;
  logic        out_last_r, out_last_nxt;

  logic        in_xfer;
  logic        unit_load;
  dig_res_t    unit_res;

  logic [4:0]  body;
  logic [4:0]  rev_idx;
  logic [7:0]  next_char;
  logic        out_free;

  assign in_stall = (state_r != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign unit_load = (state_r == S_MUL);

  itoa_digit_unit u_digit (
    .clk   (clk),
    .load  (unit_load),
    .hex   (hex_r),
    .x     (mag_r),
    .res   (unit_res)
  );

  // text length without padding, valid in S_DIG on the final digit
  assign body = 5'({1'b0, nd_r} + 5'd1 + {4'b0, neg_r});

  // position of the character being sent, counted from the right end
  assign rev_idx = total_r - 5'd1 - k_r;

  always_comb begin
    if (k_r < npad_r) begin
      next_char = zp_r ? CH_ZERO : CH_SPACE;
    end else if (neg_r && (k_r == npad_r)) begin
      next_char = CH_MINUS;
    end else begin
      next_char = digit_char(digs_r[rev_idx[3:0]]);
    end
  end

  // output register can take a new character
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    hex_nxt       = hex_r;
    zp_nxt        = zp_r;
    pad_nxt       = pad_r;
    nd_nxt        = nd_r;
    npad_nxt      = npad_r;
    total_nxt     = total_r;
    k_nxt         = k_r;
    digs_nxt      = digs_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          neg_nxt = in_signed_mode && in_value[31];
          mag_nxt = (in_signed_mode && in_value[31]) ? (32'd0 - in_value) : in_value;
          hex_nxt = in_hex_base;
          zp_nxt  = in_zero_pad;
          pad_nxt = (in_pad_width > 8'(PAD_MAX)) ? 5'(PAD_MAX) : in_pad_width[4:0];
          nd_nxt  = 4'd0;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        state_nxt = S_DIG;
      end
      S_DIG: begin
        digs_nxt[nd_r] = unit_res.digit;
        mag_nxt = unit_res.quot;
        nd_nxt  = nd_r + 4'd1;
        if ((unit_res.quot != 32'd0) && (nd_r + 4'd1 < 4'(MAX_DIGITS))) begin
          state_nxt = S_MUL;
        end else begin
          // pad count and total length from the finished digit count
          npad_nxt  = (pad_r > body) ? (pad_r - body) : 5'd0;
          total_nxt = (pad_r > body) ? pad_r : body;
          k_nxt     = 5'd0;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = next_char;
          out_last_nxt  = (k_r == total_r - 5'd1);
          k_nxt         = k_r + 5'd1;
          if (k_r == total_r - 5'd1) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    mag_r      <= mag_nxt;
    neg_r      <= neg_nxt;
    hex_r      <= hex_nxt;
    zp_r       <= zp_nxt;
    pad_r      <= pad_nxt;
    nd_r       <= nd_nxt;
    npad_r     <= npad_nxt;
    total_r    <= total_nxt;
    k_r        <= k_nxt;
    digs_r     <= digs_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_char_out = out_char_r;
  assign out_last     = out_last_r;

endmodule
